// ----- rtl/kmer_substitution_score_tally_unit_macros.svh -----
// Assertion macros shared by the tally unit's RTL.
`ifndef KMER_SUBSTITUTION_SCORE_TALLY_UNIT_MACROS_SVH
`define KMER_SUBSTITUTION_SCORE_TALLY_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define KSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/kss_pkg.sv -----
// Package for the tally unit: sizes, codes, the tally entry and helper functions.
package kss_pkg;

  // Built maximum fragment length in bases
  localparam int MAX_FRAG_LEN = 6;
  localparam int IDX_W        = 2 * MAX_FRAG_LEN;
  localparam int TABLE_DEPTH  = 1 << IDX_W;
  localparam int LEN_W        = $clog2(MAX_FRAG_LEN + 1);
  localparam int FRAG_LEN_W   = 3;
  localparam int ENTRY_W      = 16;
  localparam int SCORE_W      = ENTRY_W + $clog2(MAX_FRAG_LEN + 1);
  localparam int ROW_W        = 64;
  localparam int COUNT_W      = 40;
  localparam int TOTAL_W      = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int CMD_W        = 2;
  localparam int INDEX_IN_W   = 12;

  localparam logic [FRAG_LEN_W-1:0] FRAG_LEN_RESET = FRAG_LEN_W'(6);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAG_LEN    = 3'd0,
    REG_SCORE_ROW_T = 3'd1,
    REG_SCORE_ROW_C = 3'd2,
    REG_SCORE_ROW_A = 3'd3,
    REG_SCORE_ROW_G = 3'd4
  } kss_reg_e;

  // Input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH    = 2'd0,
    CMD_NEW_SEQ = 2'd1,
    CMD_READ    = 2'd2
  } kss_cmd_e;

  // Control states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RSP
  } kss_state_e;

  typedef logic [3:0][ROW_W-1:0] score_rows_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  // One tally table entry
  typedef struct packed {
    logic [COUNT_W-1:0]        perfect_count;
    logic [COUNT_W-1:0]        positive_count;
    logic signed [TOTAL_W-1:0] positive_total;
    logic signed [TOTAL_W-1:0] score_total;
  } tally_t;

  localparam int TALLY_W = $bits(tally_t);

  // Map an ASCII base to its two-bit code; valid flag in the top bit
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] r;
    r = 3'b000;
    case (ch)
      "T", "t": r = 3'b100;
      "C", "c": r = 3'b101;
      "A", "a": r = 3'b110;
      "G", "g": r = 3'b111;
      default:  r = 3'b000;
    endcase
    return r;
  endfunction

  // Clamp the configured fragment length into 1..MAX_FRAG_LEN
  function automatic logic [LEN_W-1:0] eff_len(input logic [FRAG_LEN_W-1:0] f);
    logic [LEN_W-1:0] r;
    if (f == '0) begin
      r = LEN_W'(1);
    end else if (int'(f) > MAX_FRAG_LEN) begin
      r = LEN_W'(MAX_FRAG_LEN);
    end else begin
      r = LEN_W'(f);
    end
    return r;
  endfunction

  // Index mask covering two bits per base of a fragment
  function automatic logic [IDX_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [IDX_W-1:0] m;
    m = '0;
    for (int i = 0; i < MAX_FRAG_LEN; i++) begin
      if (LEN_W'(i) < len) m[2*i +: 2] = 2'b11;
    end
    return m;
  endfunction

  // Substitution entry for (window base, fragment base)
  function automatic logic signed [ENTRY_W-1:0] sub_entry(input score_rows_t rows,
                                                          input logic [1:0] wb,
                                                          input logic [1:0] fb);
    logic [ROW_W-1:0] row;
    row = rows[wb];
    return row[{fb, 4'b0000} +: ENTRY_W];
  endfunction

  // Ungapped score of fragment ix against window win
  function automatic score_t frag_score(input score_rows_t rows,
                                        input logic [IDX_W-1:0] win,
                                        input logic [IDX_W-1:0] ix,
                                        input logic [LEN_W-1:0] len);
    score_t acc;
    acc = '0;
    for (int p = 0; p < MAX_FRAG_LEN; p++) begin
      if (LEN_W'(p) < len) begin
        acc = acc + SCORE_W'(sub_entry(rows, win[2*p +: 2], ix[2*p +: 2]));
      end
    end
    return acc;
  endfunction

  // Signed 64-bit add of a score, clamped at the limits
  function automatic logic signed [TOTAL_W-1:0] sat_add(input logic signed [TOTAL_W-1:0] a,
                                                        input score_t s);
    logic signed [TOTAL_W-1:0] ext;
    logic signed [TOTAL_W-1:0] sum;
    logic signed [TOTAL_W-1:0] r;
    ext = TOTAL_W'(s);
    sum = a + ext;
    r   = sum;
    if (!a[TOTAL_W-1] && !ext[TOTAL_W-1] && sum[TOTAL_W-1]) begin
      r = {1'b0, {(TOTAL_W-1){1'b1}}};
    end else if (a[TOTAL_W-1] && ext[TOTAL_W-1] && !sum[TOTAL_W-1]) begin
      r = {1'b1, {(TOTAL_W-1){1'b0}}};
    end
    return r;
  endfunction

endpackage

// ----- rtl/kss_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module kss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/kss_update.sv -----
// Tally entry update for one scored fragment: saturating counts and totals.
module kss_update
  import kss_pkg::*;
(
  input  tally_t tally_i,
  input  score_t score_i,
  input  logic   perfect_i,
  output tally_t tally_o
);

  logic positive;

  assign positive = !score_i[SCORE_W-1] && (score_i != '0);

  always_comb begin
    tally_o             = tally_i;
    // Every score goes into the total
    tally_o.score_total = sat_add(tally_i.score_total, score_i);
    // Positive scores bump the positive tallies, and a perfect match its count
    if (positive) begin
      if (tally_i.positive_count != '1) begin
        tally_o.positive_count = tally_i.positive_count + COUNT_W'(1);
      end
      tally_o.positive_total = sat_add(tally_i.positive_total, score_i);
      if (perfect_i && (tally_i.perfect_count != '1)) begin
        tally_o.perfect_count = tally_i.perfect_count + COUNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/kmer_substitution_score_tally_unit.sv -----
// Top level of the k-mer substitution score tally unit.
// Push item: once accepted, a scan of all 4^frag_len fragment entries (one table
//   read-modify-write each, paced by the single tally RAM port pair), then a drain
//   state before the next item is taken. Read item: the entry moves to the output
//   register once free, before the next item; new-sequence or non-scoring push: idle.
// Reset: a clearing pass writes zero to all 4^MAX_FRAG_LEN (4096) tally entries, one per
//   cycle; no item is taken during it, configuration writes are.
`include "kmer_substitution_score_tally_unit_macros.svh"

module kmer_substitution_score_tally_unit
  import kss_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [ROW_W-1:0]               cfg_data_i,
  // Input items
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [CMD_W-1:0]               command_i,
  input  logic [7:0]                     base_char_i,
  input  logic [INDEX_IN_W-1:0]          entry_index_i,
  // Result items
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [COUNT_W-1:0]             perfect_count_o,
  output logic [COUNT_W-1:0]             positive_count_o,
  output logic signed [TOTAL_W-1:0]      positive_total_o,
  output logic signed [TOTAL_W-1:0]      score_total_o
);

  // Configuration registers
  logic [FRAG_LEN_W-1:0] frag_len_q;
  score_rows_t           rows_q;

  // Control and window state
  kss_state_e       state_q, state_d;
  logic [IDX_W-1:0] scan_ix_q, scan_ix_d;
  logic [IDX_W-1:0] scan_win_q, scan_win_d;
  logic [IDX_W-1:0] window_q, window_d;
  logic [LEN_W-1:0] run_q, run_d;

  // Write-back stage
  logic             s1_valid_q, s1_valid_d;
  logic [IDX_W-1:0] s1_ix_q, s1_ix_d;
  score_t           s1_score_q, s1_score_d;
  logic             s1_perfect_q, s1_perfect_d;

  // Output register
  logic   out_valid_q, out_valid_d;
  logic   out_load;
  tally_t out_q;

  // Tally RAM ports
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  tally_t           ram_wdata, ram_rdata, upd_tally;
  logic [TALLY_W-1:0] ram_rdata_raw;

  // Derived values
  logic [LEN_W-1:0] len;
  logic [IDX_W-1:0] mask;
  logic [2:0]       code;
  logic [IDX_W-1:0] window_push;
  logic [LEN_W-1:0] run_inc;

  assign len         = eff_len(frag_len_q);
  assign mask        = len_mask(len);
  assign code        = base_code(base_char_i);
  assign window_push = (window_q << 2) | IDX_W'(code[1:0]);
  assign run_inc     = (int'(run_q) < MAX_FRAG_LEN) ? run_q + LEN_W'(1) : run_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frag_len_q <= FRAG_LEN_RESET;
      rows_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAG_LEN:    frag_len_q <= cfg_data_i[FRAG_LEN_W-1:0];
        REG_SCORE_ROW_T: rows_q[0]  <= cfg_data_i;
        REG_SCORE_ROW_C: rows_q[1]  <= cfg_data_i;
        REG_SCORE_ROW_A: rows_q[2]  <= cfg_data_i;
        REG_SCORE_ROW_G: rows_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state, window update, scan sequencing and RAM reads
  always_comb begin
    state_d      = state_q;
    scan_ix_d    = scan_ix_q;
    scan_win_d   = scan_win_q;
    window_d     = window_q;
    run_d        = run_q;
    s1_valid_d   = 1'b0;
    s1_ix_d      = scan_ix_q;
    s1_score_d   = frag_score(rows_q, scan_win_q, scan_ix_q, len);
    s1_perfect_d = (scan_ix_q == scan_win_q);
    ram_re       = 1'b0;
    ram_raddr    = scan_ix_q;
    out_load     = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        // Sweep zeros through the table
        scan_ix_d = scan_ix_q + IDX_W'(1);
        if (&scan_ix_q) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_PUSH: begin
              if (code[2]) begin
                window_d = window_push;
                run_d    = run_inc;
                if (run_inc >= len) begin
                  scan_ix_d  = '0;
                  scan_win_d = window_push & mask;
                  state_d    = ST_SCAN;
                end
              end else begin
                run_d = '0;
              end
            end
            CMD_NEW_SEQ: begin
              window_d = '0;
              run_d    = '0;
            end
            CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = IDX_W'(entry_index_i);
              state_d   = ST_RSP;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Read one fragment entry per cycle, score it for write-back
        ram_re     = 1'b1;
        s1_valid_d = 1'b1;
        scan_ix_d  = scan_ix_q + IDX_W'(1);
        if (scan_ix_q == mask) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Let the last write-back finish
        state_d = ST_IDLE;
      end
      ST_RSP: begin
        // Move read data into the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_ix_q   <= '0;
      scan_win_q  <= '0;
      window_q    <= '0;
      run_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_ix_q   <= scan_ix_d;
      scan_win_q  <= scan_win_d;
      window_q    <= window_d;
      run_q       <= run_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Write-back stage payload
  always_ff @(posedge clk_i) begin
    s1_ix_q      <= s1_ix_d;
    s1_score_q   <= s1_score_d;
    s1_perfect_q <= s1_perfect_d;
  end

  // Modify the entry read last cycle
  assign ram_rdata = tally_t'(ram_rdata_raw);

  kss_update u_update (
    .tally_i   (ram_rdata),
    .score_i   (s1_score_q),
    .perfect_i (s1_perfect_q),
    .tally_o   (upd_tally)
  );

  // Write back: clearing pass or updated entry
  assign ram_we    = (state_q == ST_CLEAR) || s1_valid_q;
  assign ram_waddr = (state_q == ST_CLEAR) ? scan_ix_q : s1_ix_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : upd_tally;

  kss_ram #(
    .WIDTH (TALLY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_tally_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  // Output register: hold the item until taken
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= ram_rdata;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign perfect_count_o  = out_q.perfect_count;
  assign positive_count_o = out_q.positive_count;
  assign positive_total_o = out_q.positive_total;
  assign score_total_o    = out_q.score_total;

  // Assertions
  `KSS_ASSERT(a_no_rw_same_entry, (ram_we && ram_re) |-> (ram_waddr != ram_raddr),
              "read and write hit the same tally entry")
  `KSS_ASSERT(a_drain_has_write, (state_q == ST_DRAIN) |-> s1_valid_q,
              "drain without a pending write-back")
  `KSS_ASSERT(a_out_from_rsp, $rose(out_valid_q) |-> $past(state_q == ST_RSP),
              "result raised outside a read response")
  `KSS_ASSERT_ALWAYS(a_scan_in_range, (state_q == ST_SCAN) |-> ((scan_ix_q & ~mask) == '0),
                     "scan index beyond fragment range")

endmodule

// ----- test/tally_scoreboard_pkg.sv -----
// Tally predictor and read-result checker used by the tally unit bench.
package tally_scoreboard_pkg;
  import kss_pkg::*;

  // Two-bit base codes; a fragment index packs one code per position
  typedef enum int {
    CODE_T = 0,
    CODE_C = 1,
    CODE_A = 2,
    CODE_G = 3
  } base_code_e;

  localparam int                 NOT_A_BASE  = -1;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
  localparam longint             TOTAL_HI    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint             TOTAL_LO    = 64'sh8000_0000_0000_0000;

  class tally_scoreboard;
    logic [FRAG_LEN_W-1:0] frag_len;
    logic [ROW_W-1:0]      score_rows [4];
    logic [IDX_W-1:0]      window;
    int unsigned           run_len;
    tally_t                tallies [TABLE_DEPTH];
    tally_t                expected_tallies [$];
    int unsigned           errors;
    int unsigned           items_noted;
    int unsigned           windows_scored;
    int unsigned           reads_checked;

    function new();
      frag_len = FRAG_LEN_RESET;
      foreach (score_rows[i]) score_rows[i] = '0;
      window  = '0;
      run_len = 0;
      foreach (tallies[i]) tallies[i] = '0;
      errors         = 0;
      items_noted    = 0;
      windows_scored = 0;
      reads_checked  = 0;
    endfunction

    // Mirror a configuration write
    function void set_reg(kss_reg_e r, logic [ROW_W-1:0] v);
      case (r)
        REG_FRAG_LEN:    frag_len = v[FRAG_LEN_W-1:0];
        REG_SCORE_ROW_T: score_rows[CODE_T] = v;
        REG_SCORE_ROW_C: score_rows[CODE_C] = v;
        REG_SCORE_ROW_A: score_rows[CODE_A] = v;
        REG_SCORE_ROW_G: score_rows[CODE_G] = v;
        default: ;
      endcase
    endfunction

    // Fragment length in use: zero acts as one, oversize clamps to the maximum
    function int active_len();
      if (frag_len == '0) return 1;
      if (int'(frag_len) > MAX_FRAG_LEN) return MAX_FRAG_LEN;
      return int'(frag_len);
    endfunction

    function int code_of(logic [7:0] ch);
      case (ch)
        "T", "t": return CODE_T;
        "C", "c": return CODE_C;
        "A", "a": return CODE_A;
        "G", "g": return CODE_G;
        default:  return NOT_A_BASE;
      endcase
    endfunction

    // Signed matrix entry for (window base, fragment base)
    function longint sub_score(int wb, int fb);
      logic [ROW_W-1:0]          row;
      logic signed [ENTRY_W-1:0] e;
      row = score_rows[wb];
      e   = row[ENTRY_W*fb +: ENTRY_W];
      return longint'(e);
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return TOTAL_HI;
      if (b < 0 && s > a) return TOTAL_LO;
      return s;
    endfunction

    // Score the window against every fragment and update the tallies
    function void scan(int len);
      int unsigned count;
      int unsigned win;
      longint      score;
      count = 1 << (2 * len);
      win   = int'(window) & (count - 1);
      for (int unsigned ix = 0; ix < count; ix++) begin
        score = 0;
        for (int p = 0; p < len; p++) begin
          score += sub_score(int'((win >> (2 * p)) & 3), int'((ix >> (2 * p)) & 3));
        end
        tallies[ix].score_total = sat_add(tallies[ix].score_total, score);
        if (score > 0) begin
          if (tallies[ix].positive_count != COUNT_LIMIT) begin
            tallies[ix].positive_count = tallies[ix].positive_count + 1'b1;
          end
          tallies[ix].positive_total = sat_add(tallies[ix].positive_total, score);
          if (ix == win && tallies[ix].perfect_count != COUNT_LIMIT) begin
            tallies[ix].perfect_count = tallies[ix].perfect_count + 1'b1;
          end
        end
      end
      windows_scored++;
    endfunction

    // Advance the model by one accepted item
    function void note_item(logic [CMD_W-1:0] cmd, logic [7:0] ch,
                            logic [INDEX_IN_W-1:0] idx);
      int code;
      int len;
      items_noted++;
      case (cmd)
        CMD_PUSH: begin
          code = code_of(ch);
          len  = active_len();
          if (code == NOT_A_BASE) begin
            run_len = 0;
          end else begin
            window = {window[IDX_W-3:0], 2'(code)};
            if (run_len < MAX_FRAG_LEN) run_len++;
            if (run_len >= len) scan(len);
          end
        end
        CMD_NEW_SEQ: begin
          window  = '0;
          run_len = 0;
        end
        CMD_READ: expected_tallies.push_back(tallies[idx[IDX_W-1:0]]);
        default: ;
      endcase
    endfunction

    function void check_field(string field, logic [TOTAL_W-1:0] want,
                              logic [TOTAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
    endfunction

    // Compare one result with the oldest pending read
    function void check_result(logic [COUNT_W-1:0] pc, logic [COUNT_W-1:0] pos,
                               logic [TOTAL_W-1:0] pt, logic [TOTAL_W-1:0] st);
      tally_t want;
      if (expected_tallies.size() == 0) begin
        errors++;
        $display("%0t: result with no read pending, actual %h %h %h %h",
                 $time, pc, pos, pt, st);
        return;
      end
      want = expected_tallies.pop_front();
      reads_checked++;
      check_field("perfect_count", TOTAL_W'(want.perfect_count), TOTAL_W'(pc));
      check_field("positive_count", TOTAL_W'(want.positive_count), TOTAL_W'(pos));
      check_field("positive_total", want.positive_total, pt);
      check_field("score_total", want.score_total, st);
    endfunction

    function int pending();
      return expected_tallies.size();
    endfunction
  endclass

endpackage

// ----- test/tb.sv -----
// Bench top for the tally unit: drives commands and configuration, checks every read.
module tb;
  import kss_pkg::*;
  import tally_scoreboard_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT       = 36;
  localparam int NUM_PHASES     = 7;
  localparam int RX_HOLD_CYCLES = 200;
  localparam int DRAIN_SLACK    = 16;

  typedef enum int {ROWS_RANDOM, ROWS_MAX, ROWS_MIN, ROWS_MATRIX} row_mode_e;

  // Per-phase fragment length, item count and matrix shape
  int        phase_len   [NUM_PHASES] = '{0, 3, 7, 1, 4, 6, 5};
  int        phase_items [NUM_PHASES] = '{20, 25, 8, 25, 20, 8, 11};
  row_mode_e phase_rows  [NUM_PHASES] = '{ROWS_MAX, ROWS_RANDOM, ROWS_RANDOM, ROWS_MIN,
                                          ROWS_MATRIX, ROWS_MATRIX, ROWS_MATRIX};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                    cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [ROW_W-1:0]        cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_ready_o;
  logic [CMD_W-1:0]        command_i     = '0;
  logic [7:0]              base_char_i   = '0;
  logic [INDEX_IN_W-1:0]   entry_index_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i   = 1'b0;
  logic [COUNT_W-1:0]      perfect_count_o;
  logic [COUNT_W-1:0]      positive_count_o;
  logic signed [TOTAL_W-1:0] positive_total_o;
  logic signed [TOTAL_W-1:0] score_total_o;

  tally_scoreboard tally_sb;
  bit              calm          = 1'b0;
  int              hold_requests = 0;
  int              hold_taken    = 0;
  int              rx_hold       = 0;
  logic [7:0]      real_bases [8] = '{"T", "C", "A", "G", "t", "c", "a", "g"};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  kmer_substitution_score_tally_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .base_char_i      (base_char_i),
    .entry_index_i    (entry_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .perfect_count_o  (perfect_count_o),
    .positive_count_o (positive_count_o),
    .positive_total_o (positive_total_o),
    .score_total_o    (score_total_o)
  );

  // Drive result ready: random stalls, or a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      rx_hold    = RX_HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold     = rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tally_sb.check_result(perfect_count_o, positive_count_o, positive_total_o, score_total_o);
    end
  end

  // Offer one item, idling first at random, and hold it until accepted
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] ch,
                           logic [INDEX_IN_W-1:0] idx);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    base_char_i   <= ch;
    entry_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tally_sb.note_item(cmd, ch, idx);
  endtask

  function automatic logic [ROW_W-1:0] make_row(row_mode_e mode, int wb);
    logic [ROW_W-1:0] row;
    int               v;
    row = '0;
    for (int fb = 0; fb < 4; fb++) begin
      case (mode)
        ROWS_MAX:    v = 32767;
        ROWS_MIN:    v = -32768;
        // Positive diagonal, mostly negative elsewhere
        ROWS_MATRIX: v = (fb == wb) ? int'($urandom_range(40, 1))
                                    : int'($urandom_range(60)) - 35;
        default:     v = int'($urandom);
      endcase
      row[ENTRY_W*fb +: ENTRY_W] = ENTRY_W'(v);
    end
    return row;
  endfunction

  task automatic write_reg(kss_reg_e r, logic [ROW_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    tally_sb.set_reg(r, v);
  endtask

  // Write every register; junk above the length field must be ignored
  task automatic write_config(int len, row_mode_e mode);
    logic [ROW_W-1:0] lv;
    lv = {$urandom, $urandom};
    lv[FRAG_LEN_W-1:0] = FRAG_LEN_W'(len);
    write_reg(REG_FRAG_LEN, lv);
    write_reg(REG_SCORE_ROW_T, make_row(mode, CODE_T));
    write_reg(REG_SCORE_ROW_C, make_row(mode, CODE_C));
    write_reg(REG_SCORE_ROW_A, make_row(mode, CODE_A));
    write_reg(REG_SCORE_ROW_G, make_row(mode, CODE_G));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tally_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Let a scan still running after the last result finish
  task automatic drain();
    wait_results();
    repeat ((1 << (2 * tally_sb.active_len())) + DRAIN_SLACK) @(posedge clk_i);
  endtask

  function automatic logic [INDEX_IN_W-1:0] pair_index(int first, int second);
    return INDEX_IN_W'((first << 2) | second);
  endfunction

  // Mostly real bases and reads; some breaks, restarts and unused commands
  task automatic random_item(int len, bit long_scan);
    int                    pick;
    logic [INDEX_IN_W-1:0] idx;
    logic [7:0]            ch;
    pick = int'($urandom_range(99));
    idx  = INDEX_IN_W'($urandom);
    ch   = 8'($urandom);
    if (long_scan) pick = (pick < 80) ? 0 : 99;
    if (pick < 55) begin
      send_item(CMD_PUSH, real_bases[$urandom_range(7)], idx);
    end else if (pick < 63) begin
      send_item(CMD_PUSH, ch, idx);
    end else if (pick < 68) begin
      send_item(CMD_NEW_SEQ, ch, idx);
    end else if (pick < 70) begin
      send_item(CMD_UNUSED, ch, idx);
    end else begin
      if ($urandom_range(9) < 7) idx = idx & INDEX_IN_W'((1 << (2 * len)) - 1);
      send_item(CMD_READ, ch, idx);
    end
  endtask

  // Directed pass at fragment length two
  task automatic run_directed();
    send_item(CMD_PUSH, 8'h00, '1);
    send_item(CMD_PUSH, 8'hFF, '0);
    send_item(CMD_PUSH, "A", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "c", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "G", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "t", INDEX_IN_W'($urandom));
    send_item(CMD_READ, 8'($urandom), pair_index(CODE_G, CODE_T));
    send_item(CMD_READ, 8'($urandom), '0);
    send_item(CMD_READ, 8'($urandom), '1);
    // non-base breaks the run; a single base after it scores nothing
    send_item(CMD_PUSH, "N", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "a", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "g", INDEX_IN_W'($urandom));
    send_item(CMD_READ, 8'($urandom), pair_index(CODE_A, CODE_G));
    send_item(CMD_NEW_SEQ, 8'($urandom), INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "T", INDEX_IN_W'($urandom));
    send_item(CMD_UNUSED, 8'($urandom), INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "T", INDEX_IN_W'($urandom));
    send_item(CMD_READ, 8'($urandom), pair_index(CODE_T, CODE_T));
    send_item(CMD_PUSH, "C", INDEX_IN_W'($urandom));
    send_item(CMD_PUSH, "a", INDEX_IN_W'($urandom));
    send_item(CMD_READ, 8'($urandom), pair_index(CODE_C, CODE_A));
    send_item(CMD_NEW_SEQ, 8'($urandom), INDEX_IN_W'($urandom));
    send_item(CMD_READ, 8'($urandom), pair_index(CODE_C, CODE_T));
  endtask

  initial begin
    tally_sb = new();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Configure during the clearing pass, then run the directed items
    write_config(2, ROWS_MATRIX);
    run_directed();
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_config(phase_len[ph], phase_rows[ph]);
      calm = (ph == 1);
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == 3 && n == 2) hold_requests++;
        if (ph == 4 && n == phase_items[ph] / 2) wait_results();
        random_item(tally_sb.active_len(), phase_len[ph] >= 5);
      end
      drain();
    end

    $display("Covered %0d items, %0d scored windows and %0d checked reads,",
             tally_sb.items_noted, tally_sb.windows_scored, tally_sb.reads_checked);
    $display("over %0d settings of fragment length and matrix, with stalls on both sides.",
             NUM_PHASES + 1);
    if (tally_sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #4000000;
    $display("Timeout with %0d reads pending", tally_sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
